[rtl/bc1pi_pkg.sv]
// ----------------------------------------------------------------------------
// bc1pi_pkg
// Shared types, constants and helper functions for the BC1 palette
// interpolator: rounding modes, pipeline control, endpoint unpacking,
// channel widening and the interpolation arithmetic common to all channels.
// ----------------------------------------------------------------------------
`default_nettype none

package bc1pi_pkg;

	// Field widths of the words on the channels.
	localparam int unsigned RGB565_W  = 16;
	localparam int unsigned RGBA_W    = 32;
	localparam int unsigned CH_W      = 8;
	localparam int unsigned RB_RAW_W  = 5;
	localparam int unsigned G_RAW_W   = 6;
	localparam int unsigned MODE_W    = 2;

	// Intermediate widths of the interpolation numerators.
	localparam int unsigned THIRD_NUM_W = 14;
	localparam int unsigned HALF_NUM_W  = 9;

	// Weights of the rounding rules.
	localparam logic [THIRD_NUM_W-1:0] HWA_NEAR_WT = 14'd43;
	localparam logic [THIRD_NUM_W-1:0] HWA_FAR_WT  = 14'd21;
	localparam logic [THIRD_NUM_W-1:0] HWA_BIAS    = 14'd32;
	localparam logic [19:0]            DIV3_RECIP  = 20'd683;

	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

	// Rounding rule of the interpolated entries.
	typedef enum logic [MODE_W-1:0] {
		MODE_IDEAL_TRUNC = 2'd0,
		MODE_IDEAL_ROUND = 2'd1,
		MODE_HW_N        = 2'd2,
		MODE_HW_A        = 2'd3
	} interp_mode_t;

	// Stage load enables handed to the channel datapaths.
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} pipe_ctl_t;

	// Endpoint field extraction.
	function automatic logic [RB_RAW_W-1:0] red_of(logic [RGB565_W-1:0] e);
		return e[15:11];
	endfunction

	function automatic logic [G_RAW_W-1:0] green_of(logic [RGB565_W-1:0] e);
		return e[10:5];
	endfunction

	function automatic logic [RB_RAW_W-1:0] blue_of(logic [RGB565_W-1:0] e);
		return e[4:0];
	endfunction

	// Widening by bit replication.
	function automatic logic [CH_W-1:0] widen5(logic [RB_RAW_W-1:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [CH_W-1:0] widen6(logic [G_RAW_W-1:0] v);
		return {v, v[5:4]};
	endfunction

	function automatic logic [RGBA_W-1:0] pack_rgba(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b, logic [CH_W-1:0] a);
		return {a, b, g, r};
	endfunction

	// Numerator of the third point nearer a, on widened channels.
	function automatic logic [THIRD_NUM_W-1:0] third_num(interp_mode_t m,
			logic [CH_W-1:0] a, logic [CH_W-1:0] b);
		logic [THIRD_NUM_W-1:0] a14;
		logic [THIRD_NUM_W-1:0] b14;
		a14 = THIRD_NUM_W'(a);
		b14 = THIRD_NUM_W'(b);
		priority if (m == MODE_HW_A) begin
			return a14 * HWA_NEAR_WT + b14 * HWA_FAR_WT + HWA_BIAS;
		end else if (m == MODE_IDEAL_ROUND) begin
			return (a14 << 1) + b14 + THIRD_NUM_W'(1);
		end else begin
			return (a14 << 1) + b14;
		end
	endfunction

	// Divide a value below 1024 by three through a reciprocal multiply.
	function automatic logic [CH_W-1:0] div3(logic [9:0] n);
		logic [19:0] p;
		p = 20'(n) * DIV3_RECIP;
		return p[18:11];
	endfunction

	// Final value of the third point from its numerator.
	function automatic logic [CH_W-1:0] third_fin(interp_mode_t m,
			logic [THIRD_NUM_W-1:0] num);
		if (m == MODE_HW_A) begin
			return num[13:6];
		end
		return div3(num[9:0]);
	endfunction

	// Numerator of the midpoint on widened channels.
	function automatic logic [HALF_NUM_W-1:0] half_num(interp_mode_t m,
			logic [CH_W-1:0] a, logic [CH_W-1:0] b);
		logic [HALF_NUM_W-1:0] s;
		s = HALF_NUM_W'(a) + HALF_NUM_W'(b);
		if (m == MODE_HW_A) begin
			s = s + HALF_NUM_W'(1);
		end
		return s;
	endfunction

endpackage

`default_nettype wire

[rtl/bc1pi_if.sv]
// ----------------------------------------------------------------------------
// bc1pi_if
// Valid/ready channels of the palette interpolator: the endpoint word
// going in and the palette word coming out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bc1pi_in_if;
	logic                             valid;
	logic                             ready;
	logic [bc1pi_pkg::RGB565_W-1:0]   endpoint_0;
	logic [bc1pi_pkg::RGB565_W-1:0]   endpoint_1;

	modport source (output valid, output endpoint_0, output endpoint_1, input ready);
	modport sink (input valid, input endpoint_0, input endpoint_1, output ready);
endinterface

interface bc1pi_out_if;
	logic                           valid;
	logic                           ready;
	logic [bc1pi_pkg::RGBA_W-1:0]   palette_0;
	logic [bc1pi_pkg::RGBA_W-1:0]   palette_1;
	logic [bc1pi_pkg::RGBA_W-1:0]   palette_2;
	logic [bc1pi_pkg::RGBA_W-1:0]   palette_3;
	logic                           three_color;

	modport source (output valid, output palette_0, output palette_1, output palette_2,
		output palette_3, output three_color, input ready);
	modport sink (input valid, input palette_0, input palette_1, input palette_2,
		input palette_3, input three_color, output ready);
endinterface

`default_nettype wire

[rtl/bc1pi_rb_interp.sv]
// ----------------------------------------------------------------------------
// bc1pi_rb_interp
// Interpolated entries 2 and 3 of a 5-bit channel (red or blue). Stage 2
// forms the numerators, stage 3 scales them down and applies the three-color
// select between midpoint and third points.
// ----------------------------------------------------------------------------
`default_nettype none

module bc1pi_rb_interp (
	input  wire logic                              clk,
	input  wire bc1pi_pkg::pipe_ctl_t              ctl,
	input  wire bc1pi_pkg::interp_mode_t           mode,
	input  wire logic [bc1pi_pkg::RB_RAW_W-1:0]    c0,
	input  wire logic [bc1pi_pkg::RB_RAW_W-1:0]    c1,
	input  wire logic                              three,
	output logic [bc1pi_pkg::CH_W-1:0]             e2,
	output logic [bc1pi_pkg::CH_W-1:0]             e3
);
	import bc1pi_pkg::*;

	localparam logic [THIRD_NUM_W-1:0] RAW_THIRD_WT = 14'd22;
	localparam logic [10:0]            RAW_HALF_WT  = 11'd33;

	logic [CH_W-1:0]        a;
	logic [CH_W-1:0]        b;
	logic [6:0]             raw_t0;
	logic [6:0]             raw_t1;
	logic [THIRD_NUM_W-1:0] t0_num;
	logic [THIRD_NUM_W-1:0] t1_num;
	logic [10:0]            h_num;
	logic [THIRD_NUM_W-1:0] t0_num_s2;
	logic [THIRD_NUM_W-1:0] t1_num_s2;
	logic [10:0]            h_num_s2;
	logic [CH_W-1:0]        t0_val;
	logic [CH_W-1:0]        t1_val;
	logic [CH_W-1:0]        h_val;

	// Stage 2 numerators; the raw-value rule works on the unwidened fields.
	always_comb begin
		a      = widen5(c0);
		b      = widen5(c1);
		raw_t0 = 7'({c0, 1'b0}) + 7'(c1);
		raw_t1 = 7'({c1, 1'b0}) + 7'(c0);
		if (mode == MODE_HW_N) begin
			t0_num = THIRD_NUM_W'(raw_t0) * RAW_THIRD_WT;
			t1_num = THIRD_NUM_W'(raw_t1) * RAW_THIRD_WT;
			h_num  = 11'({1'b0, c0} + {1'b0, c1}) * RAW_HALF_WT;
		end else begin
			t0_num = third_num(mode, a, b);
			t1_num = third_num(mode, b, a);
			h_num  = 11'(half_num(mode, a, b));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			t0_num_s2 <= t0_num;
			t1_num_s2 <= t1_num;
			h_num_s2  <= h_num;
		end
	end

	// Stage 3 scaling of the numerators.
	always_comb begin
		if (mode == MODE_HW_N) begin
			t0_val = t0_num_s2[10:3];
			t1_val = t1_num_s2[10:3];
			h_val  = h_num_s2[10:3];
		end else begin
			t0_val = third_fin(mode, t0_num_s2);
			t1_val = third_fin(mode, t1_num_s2);
			h_val  = h_num_s2[8:1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			e2 <= three ? h_val : t0_val;
			e3 <= three ? ALPHA_CLEAR : t1_val;
		end
	end

endmodule

`default_nettype wire

[rtl/bc1pi_g_interp.sv]
// ----------------------------------------------------------------------------
// bc1pi_g_interp
// Interpolated entries 2 and 3 of the 6-bit green channel. The hardware
// rule of mode two uses a signed weighted sum of the endpoint difference,
// clamped at zero; the other modes share the common arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module bc1pi_g_interp (
	input  wire logic                             clk,
	input  wire bc1pi_pkg::pipe_ctl_t             ctl,
	input  wire bc1pi_pkg::interp_mode_t          mode,
	input  wire logic [bc1pi_pkg::G_RAW_W-1:0]    c0,
	input  wire logic [bc1pi_pkg::G_RAW_W-1:0]    c1,
	input  wire logic                             three,
	output logic [bc1pi_pkg::CH_W-1:0]            e2,
	output logic [bc1pi_pkg::CH_W-1:0]            e3
);
	import bc1pi_pkg::*;

	localparam logic [CH_W-1:0] THIRD_WT = 8'd80;
	localparam logic [CH_W-1:0] HALF_WT  = 8'd128;

	logic [CH_W-1:0]        a;
	logic [CH_W-1:0]        b;
	logic signed [17:0]     t0_num;
	logic signed [17:0]     t1_num;
	logic signed [17:0]     h_num;
	logic signed [17:0]     t0_num_s2;
	logic signed [17:0]     t1_num_s2;
	logic signed [17:0]     h_num_s2;
	logic [CH_W-1:0]        t0_val;
	logic [CH_W-1:0]        t1_val;
	logic [CH_W-1:0]        h_val;

	// Weighted sum 256a + d/4 + 128 + w*d with d = b - a; d/4 truncates
	// toward zero.
	function automatic logic signed [17:0] hw_sum(logic [CH_W-1:0] pa, logic [CH_W-1:0] pb,
			logic [CH_W-1:0] w);
		logic signed [17:0] sa;
		logic signed [17:0] sd;
		logic signed [17:0] dq;
		sa = $signed({10'd0, pa});
		sd = $signed({10'd0, pb}) - sa;
		dq = (sd + (sd[17] ? 18'sd3 : 18'sd0)) >>> 2;
		return (sa <<< 8) + dq + 18'sd128 + sd * $signed({10'd0, w});
	endfunction

	// Clamp the hardware sum at zero and keep bits 15:8.
	function automatic logic [CH_W-1:0] hw_fin(logic signed [17:0] s);
		if (s[17]) begin
			return ALPHA_CLEAR;
		end
		return s[15:8];
	endfunction

	// Stage 2 numerators.
	always_comb begin
		a = widen6(c0);
		b = widen6(c1);
		if (mode == MODE_HW_N) begin
			t0_num = hw_sum(a, b, THIRD_WT);
			t1_num = hw_sum(b, a, THIRD_WT);
			h_num  = hw_sum(a, b, HALF_WT);
		end else begin
			t0_num = $signed(18'(third_num(mode, a, b)));
			t1_num = $signed(18'(third_num(mode, b, a)));
			h_num  = $signed(18'(half_num(mode, a, b)));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			t0_num_s2 <= t0_num;
			t1_num_s2 <= t1_num;
			h_num_s2  <= h_num;
		end
	end

	// Stage 3 scaling of the numerators.
	always_comb begin
		if (mode == MODE_HW_N) begin
			t0_val = hw_fin(t0_num_s2);
			t1_val = hw_fin(t1_num_s2);
			h_val  = hw_fin(h_num_s2);
		end else begin
			t0_val = third_fin(mode, t0_num_s2[13:0]);
			t1_val = third_fin(mode, t1_num_s2[13:0]);
			h_val  = h_num_s2[8:1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			e2 <= three ? h_val : t0_val;
			e3 <= three ? ALPHA_CLEAR : t1_val;
		end
	end

endmodule

`default_nettype wire

[rtl/bc1_palette_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// bc1_palette_interpolator_unit
// Decodes a BC1 color block's two RGB565 endpoints into its four-entry
// RGBA8888 palette and the three-color flag.
// ----------------------------------------------------------------------------
// Usage:
// An endpoint word enters on the endpoints channel when valid and ready are
// both high; the palette word leaves on the palette channel under the same
// rule. The datapath is a three-stage pipeline: stage 1 registers the
// endpoints and the three-color compare, stage 2 registers the weighted
// numerators, stage 3 registers the scaled and selected entries, which are
// the output register. A word accepted into stage 1 passes through stages 2
// and 3 and is offered on the palette channel from the output register, and
// one word is accepted in every cycle while the receiver keeps up.
// When the receiver holds ready low, the stages stay full and a bubble in
// front of a full stage still closes up; endpoints.ready drops only once
// every stage holds a word. Reset empties the pipeline and sets the rounding
// mode to ideal truncating. The mode register is written through cfg_we and
// cfg_wdata and must only change while no word is in the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bc1_palette_interpolator_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bc1pi_pkg::MODE_W-1:0]     cfg_wdata,
	bc1pi_in_if.sink                              endpoints,
	bc1pi_out_if.source                           palette
);
	import bc1pi_pkg::*;

	interp_mode_t           mode_q;
	pipe_ctl_t              ctl;
	logic                   en_s1;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   valid_s3;
	logic [RGB565_W-1:0]    e0_s1;
	logic [RGB565_W-1:0]    e1_s1;
	logic                   three_s1;
	logic [RGB565_W-1:0]    e0_s2;
	logic [RGB565_W-1:0]    e1_s2;
	logic                   three_s2;
	logic [RGB565_W-1:0]    e0_s3;
	logic [RGB565_W-1:0]    e1_s3;
	logic                   three_s3;
	logic [CH_W-1:0]        r_e2;
	logic [CH_W-1:0]        r_e3;
	logic [CH_W-1:0]        g_e2;
	logic [CH_W-1:0]        g_e3;
	logic [CH_W-1:0]        b_e2;
	logic [CH_W-1:0]        b_e3;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDEAL_TRUNC;
		end else if (cfg_we) begin
			mode_q <= interp_mode_t'(cfg_wdata);
		end
	end

	// Stage enables: a stage loads when it is empty or its word moves on.
	always_comb begin
		ctl.en_s3 = !valid_s3 || palette.ready;
		ctl.en_s2 = !valid_s2 || ctl.en_s3;
		en_s1     = !valid_s1 || ctl.en_s2;
	end

	assign endpoints.ready = en_s1;

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= endpoints.valid;
			end
			if (ctl.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ctl.en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Endpoint words and mode flag travelling with the datapath.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			e0_s1    <= endpoints.endpoint_0;
			e1_s1    <= endpoints.endpoint_1;
			three_s1 <= (endpoints.endpoint_1 >= endpoints.endpoint_0);
		end
		if (ctl.en_s2) begin
			e0_s2    <= e0_s1;
			e1_s2    <= e1_s1;
			three_s2 <= three_s1;
		end
		if (ctl.en_s3) begin
			e0_s3    <= e0_s2;
			e1_s3    <= e1_s2;
			three_s3 <= three_s2;
		end
	end

	// Channel datapaths for the interpolated entries.
	bc1pi_rb_interp u_red (
		.clk   (clk),
		.ctl   (ctl),
		.mode  (mode_q),
		.c0    (red_of(e0_s1)),
		.c1    (red_of(e1_s1)),
		.three (three_s2),
		.e2    (r_e2),
		.e3    (r_e3)
	);

	bc1pi_g_interp u_green (
		.clk   (clk),
		.ctl   (ctl),
		.mode  (mode_q),
		.c0    (green_of(e0_s1)),
		.c1    (green_of(e1_s1)),
		.three (three_s2),
		.e2    (g_e2),
		.e3    (g_e3)
	);

	bc1pi_rb_interp u_blue (
		.clk   (clk),
		.ctl   (ctl),
		.mode  (mode_q),
		.c0    (blue_of(e0_s1)),
		.c1    (blue_of(e1_s1)),
		.three (three_s2),
		.e2    (b_e2),
		.e3    (b_e3)
	);

	// Output word packing.
	assign palette.valid       = valid_s3;
	assign palette.three_color = three_s3;
	assign palette.palette_0   = pack_rgba(widen5(red_of(e0_s3)), widen6(green_of(e0_s3)),
		widen5(blue_of(e0_s3)), ALPHA_OPAQUE);
	assign palette.palette_1   = pack_rgba(widen5(red_of(e1_s3)), widen6(green_of(e1_s3)),
		widen5(blue_of(e1_s3)), ALPHA_OPAQUE);
	assign palette.palette_2   = pack_rgba(r_e2, g_e2, b_e2, ALPHA_OPAQUE);
	assign palette.palette_3   = pack_rgba(r_e3, g_e3, b_e3,
		three_s3 ? ALPHA_CLEAR : ALPHA_OPAQUE);

`ifndef SYNTHESIS
	// In three-color mode entry 3 is transparent black.
	a_three_clear: assert property (@(posedge clk) disable iff (!arst_n)
		palette.valid && palette.three_color |-> palette.palette_3 == '0)
		else $error("entry 3 not transparent black in three-color mode");

	// In four-color mode both interpolated entries are opaque; entries 0 and 1 always are.
	a_four_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		palette.valid && !palette.three_color |-> palette.palette_3[31:24] == ALPHA_OPAQUE
		&& palette.palette_2[31:24] == ALPHA_OPAQUE)
		else $error("interpolated entry not opaque in four-color mode");

	// A word held in stage 2 by a full output stage stays put.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ctl.en_s3 |=> valid_s2 && $stable(e0_s2) && $stable(e1_s2))
		else $error("stage 2 word changed while stalled");
`endif

endmodule

`default_nettype wire

[tb/sv/bc1_palette_interpolator_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bc1_palette_interpolator_unit_tb
// Drives endpoint words into the palette interpolator under random gaps and
// back-pressure, in every rounding mode, and checks each palette word against
// a bit-exact software decode of the BC1 palette held in a small scoreboard.
// ----------------------------------------------------------------------------

module bc1_palette_interpolator_unit_tb;

	import bc1pi_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int unsigned PHASE_WORDS   = 217;
	localparam int unsigned HOLD_CYCLES   = 60;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned DIRECTED_N    = 18;

	// Endpoint pairs {endpoint_0, endpoint_1} for the directed part.
	localparam logic [31:0] DIRECTED [DIRECTED_N] = '{
		{16'h0000, 16'h0000}, // equal endpoints at zero
		{16'hFFFF, 16'hFFFF}, // equal endpoints at full scale
		{16'hFFFF, 16'h0000}, // four-color, full range
		{16'h0000, 16'hFFFF}, // three-color, full range
		{16'hF800, 16'h07E0},
		{16'h07E0, 16'hF800},
		{16'h001F, 16'h07E0},
		{16'hF800, 16'h001F},
		{16'h8000, 16'h7FFF},
		{16'h7FFF, 16'h8000},
		{16'h1234, 16'h1233}, // four-color by one step
		{16'h1233, 16'h1234}, // three-color by one step
		{16'h07E0, 16'h0020}, // green falls from 63 to 1
		{16'h0020, 16'h07E0},
		{16'h0841, 16'hFFBE},
		{16'hAAAA, 16'h5555},
		{16'h5555, 16'hAAAA},
		{16'hFFDF, 16'h0020}
	};

	localparam interp_mode_t PHASE_MODES [8] = '{
		MODE_IDEAL_ROUND, MODE_HW_A, MODE_HW_N, MODE_IDEAL_TRUNC,
		MODE_HW_N, MODE_HW_A, MODE_IDEAL_ROUND, MODE_IDEAL_TRUNC
	};

	typedef struct {
		logic [RGBA_W-1:0] entry_0;
		logic [RGBA_W-1:0] entry_1;
		logic [RGBA_W-1:0] entry_2;
		logic [RGBA_W-1:0] entry_3;
		logic              three_color;
	} palette_word_t;

	// Predicts the palette of each accepted endpoint word and checks the
	// palette words that come out against those predictions in order.
	class palette_scoreboard;
		interp_mode_t  mode = MODE_IDEAL_TRUNC;
		palette_word_t pending_palettes[$];
		int unsigned   mismatches = 0;

		function int grow5(int v);
			return (v << 3) | (v >> 2);
		endfunction

		function int grow6(int v);
			return (v << 2) | (v >> 4);
		endfunction

		// Third point nearer a on widened channels.
		function int third_channel(int a, int b);
			if (mode == MODE_IDEAL_ROUND) begin
				return (2 * a + b + 1) / 3;
			end
			if (mode == MODE_HW_A) begin
				return (43 * a + 21 * b + 32) >> 6;
			end
			return (2 * a + b) / 3;
		endfunction

		// Midpoint on widened channels.
		function int mid_channel(int a, int b);
			if (mode == MODE_HW_A) begin
				return (a + b + 1) >> 1;
			end
			return (a + b) >> 1;
		endfunction

		// Hardware-N green: the quarter step truncates toward zero.
		function int green_hw_n(int a, int b, int weight);
			int d;
			int s;
			d = b - a;
			s = 256 * a + d / 4 + 128 + d * weight;
			if (s < 0) begin
				s = 0;
			end
			return (s >> 8) & 255;
		endfunction

		function logic [RGBA_W-1:0] rgba(int r, int g, int b, int a);
			return {8'(a), 8'(b), 8'(g), 8'(r)};
		endfunction

		// Third point of the line, lying nearer the endpoint near_e.
		function logic [RGBA_W-1:0] third_point(logic [15:0] near_e, logic [15:0] far_e);
			int r0, g0, b0, r1, g1, b1;
			r0 = int'(near_e[15:11]);
			g0 = int'(near_e[10:5]);
			b0 = int'(near_e[4:0]);
			r1 = int'(far_e[15:11]);
			g1 = int'(far_e[10:5]);
			b1 = int'(far_e[4:0]);
			if (mode == MODE_HW_N) begin
				return rgba(((2 * r0 + r1) * 22) / 8, green_hw_n(grow6(g0), grow6(g1), 80),
					((2 * b0 + b1) * 22) / 8, 255);
			end
			return rgba(third_channel(grow5(r0), grow5(r1)),
				third_channel(grow6(g0), grow6(g1)),
				third_channel(grow5(b0), grow5(b1)), 255);
		endfunction

		function logic [RGBA_W-1:0] mid_point(logic [15:0] e0, logic [15:0] e1);
			int r0, g0, b0, r1, g1, b1;
			r0 = int'(e0[15:11]);
			g0 = int'(e0[10:5]);
			b0 = int'(e0[4:0]);
			r1 = int'(e1[15:11]);
			g1 = int'(e1[10:5]);
			b1 = int'(e1[4:0]);
			if (mode == MODE_HW_N) begin
				return rgba(((r0 + r1) * 33) / 8, green_hw_n(grow6(g0), grow6(g1), 128),
					((b0 + b1) * 33) / 8, 255);
			end
			return rgba(mid_channel(grow5(r0), grow5(r1)), mid_channel(grow6(g0), grow6(g1)),
				mid_channel(grow5(b0), grow5(b1)), 255);
		endfunction

		// An endpoint word was accepted: queue the palette it must produce.
		function void note_endpoints(logic [15:0] e0, logic [15:0] e1);
			palette_word_t want;
			want.entry_0 = rgba(grow5(int'(e0[15:11])), grow6(int'(e0[10:5])),
				grow5(int'(e0[4:0])), 255);
			want.entry_1 = rgba(grow5(int'(e1[15:11])), grow6(int'(e1[10:5])),
				grow5(int'(e1[4:0])), 255);
			want.three_color = (e1 >= e0);
			if (want.three_color) begin
				want.entry_2 = mid_point(e0, e1);
				want.entry_3 = '0;
			end else begin
				want.entry_2 = third_point(e0, e1);
				want.entry_3 = third_point(e1, e0);
			end
			pending_palettes.push_back(want);
		endfunction

		function void flag(string what, logic [RGBA_W-1:0] want, logic [RGBA_W-1:0] got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("palette mismatch on %s: expected %08h, got %08h", what, want, got);
			end
		endfunction

		// A palette word was accepted: compare it with the oldest prediction.
		function void check_palette(palette_word_t got);
			palette_word_t want;
			if (pending_palettes.size() == 0) begin
				flag("a word with nothing pending, entry 0", '0, got.entry_0);
				return;
			end
			want = pending_palettes.pop_front();
			if (got.entry_0 !== want.entry_0) flag("entry 0", want.entry_0, got.entry_0);
			if (got.entry_1 !== want.entry_1) flag("entry 1", want.entry_1, got.entry_1);
			if (got.entry_2 !== want.entry_2) flag("entry 2", want.entry_2, got.entry_2);
			if (got.entry_3 !== want.entry_3) flag("entry 3", want.entry_3, got.entry_3);
			if (got.three_color !== want.three_color) begin
				flag("three_color", RGBA_W'(want.three_color), RGBA_W'(got.three_color));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [MODE_W-1:0] cfg_wdata = '0;

	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;
	bit hold_request = 1'b0;
	int unsigned cycle_count = 0;

	palette_scoreboard palette_sb;

	bc1pi_in_if  endpoints_ch ();
	bc1pi_out_if palette_ch ();

	bc1_palette_interpolator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.endpoints (endpoints_ch),
		.palette   (palette_ch)
	);

	always #2 clk = ~clk;

	// Run time guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// One field value: zero, full scale or anything in between.
	function automatic logic [5:0] pick_field(int unsigned top);
		case ($urandom_range(0, 2))
			0: return '0;
			1: return 6'(top);
			default: return 6'($urandom_range(0, top));
		endcase
	endfunction

	function automatic logic [15:0] random_endpoint();
		if ($urandom_range(0, 1) == 1) begin
			return 16'($urandom);
		end
		return {5'(pick_field(31)), pick_field(63), 5'(pick_field(31))};
	endfunction

	// A random endpoint pair, with equal and near-equal pairs mixed in.
	function automatic logic [31:0] random_pair();
		logic [15:0] a;
		logic [15:0] b;
		a = random_endpoint();
		case ($urandom_range(0, 9))
			0: return DIRECTED[$urandom_range(0, DIRECTED_N - 1)];
			1: b = a;
			2: b = a + 16'($urandom_range(0, 3)) - 16'($urandom_range(0, 3));
			default: b = random_endpoint();
		endcase
		return {a, b};
	endfunction

	// Offer one endpoint word after a random gap (none in a send burst); returns
	// right after the rising edge that accepts it.
	task automatic send_endpoints(logic [15:0] e0, logic [15:0] e1);
		int unsigned gap;
		gap = send_burst ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			endpoints_ch.valid = 1'b0;
		end
		@(negedge clk);
		endpoints_ch.valid = 1'b1;
		endpoints_ch.endpoint_0 = e0;
		endpoints_ch.endpoint_1 = e1;
		do @(posedge clk); while (!endpoints_ch.ready);
		palette_sb.note_endpoints(e0, e1);
	endtask

	// Stop offering and wait until every predicted palette has come out.
	task automatic wait_drain();
		@(negedge clk);
		endpoints_ch.valid = 1'b0;
		while (palette_sb.pending_palettes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mode write; called at a falling edge with the pipeline empty.
	task automatic write_mode(interp_mode_t m);
		cfg_we = 1'b1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_we = 1'b0;
		palette_sb.mode = m;
	endtask

	// Palette side: random stalls, an occasional long hold, and checking.
	initial begin : palette_sink
		int unsigned stall_left;
		int unsigned hold_left;
		palette_word_t got;
		stall_left = 0;
		hold_left = 0;
		palette_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				palette_ch.ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				palette_ch.ready = 1'b0;
				stall_left--;
			end else begin
				palette_ch.ready = 1'b1;
			end
			@(posedge clk);
			if (arst_n && palette_ch.valid && palette_ch.ready) begin
				got.entry_0 = palette_ch.palette_0;
				got.entry_1 = palette_ch.palette_1;
				got.entry_2 = palette_ch.palette_2;
				got.entry_3 = palette_ch.palette_3;
				got.three_color = palette_ch.three_color;
				palette_sb.check_palette(got);
				stall_left = recv_burst ? 0 : $urandom_range(0, 5);
			end
		end
	end

	// Endpoint side: directed words in the reset mode, then a random phase
	// in each of several modes.
	initial begin : endpoint_source
		logic [31:0] pair;
		palette_sb = new;
		endpoints_ch.valid = 1'b0;
		endpoints_ch.endpoint_0 = '0;
		endpoints_ch.endpoint_1 = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i]) begin
			send_endpoints(DIRECTED[i][31:16], DIRECTED[i][15:0]);
		end

		for (int p = 0; p < 8; p++) begin
			wait_drain();
			write_mode(PHASE_MODES[p]);
			send_burst = (p % 3 == 2);
			recv_burst = (p % 4 == 1);
			// Long receiver hold while words keep coming, to fill the pipeline.
			if (p == 2) begin
				hold_request = 1'b1;
				send_burst = 1'b1;
			end
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (i == PHASE_WORDS / 2) begin
					wait_drain();
				end
				pair = random_pair();
				send_endpoints(pair[31:16], pair[15:0]);
			end
		end

		wait_drain();
		if (palette_sb.mismatches == 0 && palette_sb.pending_palettes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/bc1pi_pkg.sv
rtl/bc1pi_if.sv
rtl/bc1pi_rb_interp.sv
rtl/bc1pi_g_interp.sv
rtl/bc1_palette_interpolator_unit.sv
tb/sv/bc1_palette_interpolator_unit_tb.sv
